>>> hdl/gcm_pkg.sv
package gcm_pkg;

  localparam int POS_W         = 32;
  localparam int POS_FRAC_BITS = 16;
  localparam int MAX_STEPS     = 7;
  localparam int IDX_W         = 3;
  localparam int CHAN_W        = 8;
  localparam int FRAC_W        = 8;
  localparam int COLOR_W       = 4 * CHAN_W;
  localparam int STEP_W        = POS_W + COLOR_W;
  localparam int CFG_IDX_W     = 3;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = CFG_IDX_W'(0);
  localparam int                   REG_STEP_BASE  = 1;

  // reset contents
  localparam logic [IDX_W-1:0]  STEP_COUNT_RESET = IDX_W'(2);
  localparam logic [STEP_W-1:0] STEP0_RESET      = STEP_W'(255);
  localparam logic [STEP_W-1:0] STEP1_RESET      =
    {POS_W'(1) << POS_FRAC_BITS, {COLOR_W{1'b1}}};

  // one item inside the fraction divider
  typedef struct packed {
    logic [POS_W-1:0]  rem;
    logic [POS_W-1:0]  span;
    logic [FRAC_W-1:0] quo;
    logic [IDX_W-1:0]  lo_idx;
    logic [IDX_W-1:0]  hi_idx;
    logic              zero;
    logic              alpha;
  } div_t;

endpackage

>>> hdl/gcm_in_if.sv
interface gcm_in_if;
  import gcm_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [POS_W-1:0] position;
  logic              position_is_nan;
  logic              include_alpha;

  modport source (output valid, position, position_is_nan, include_alpha, input ready);
  modport sink   (input valid, position, position_is_nan, include_alpha, output ready);
endinterface

>>> hdl/gcm_out_if.sv
interface gcm_out_if;
  import gcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;
  logic              alpha_valid;

  modport source (output valid, red, green, blue, alpha, alpha_valid, input ready);
  modport sink   (input valid, red, green, blue, alpha, alpha_valid, output ready);
endinterface

>>> hdl/gcm_cfg_if.sv
interface gcm_cfg_if;
  import gcm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [STEP_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/gradient_color_map.sv
// Maps a signed fixed-point scalar to an RGBA8 color through a piecewise linear
// gradient of up to NUM_STEPS configured steps (sorted by position). The block is
// a 12-stage pipeline: compare against all step positions, pick the bracketing
// steps, form offset and span, eight stages of a one-bit-per-stage restoring
// divider for the 8-bit fraction, then the channel blend into the output
// register. It takes one item per clock unless stalled; the whole pipeline holds
// while a result waits at the output. Steps are to be written through the
// configuration channel only while the block is idle; the block itself does not
// enforce this, and that channel is always ready.
module gradient_color_map
  import gcm_pkg::*;
#(
  parameter int NUM_STEPS = MAX_STEPS
) (
  input logic         clk,
  input logic         rst_n,
  gcm_in_if.sink      in_if,
  gcm_out_if.source   out_if,
  gcm_cfg_if.sink     cfg_if
);

  localparam int SIDX_W    = $clog2(NUM_STEPS);
  localparam int DIV_STAGES = FRAC_W;
  localparam int PROD_W    = 2 * CHAN_W + 1;

  // configuration
  logic [IDX_W-1:0]  step_count_r;
  logic [STEP_W-1:0] steps_r [NUM_STEPS];
  logic              cfg_acc;
  logic [IDX_W-1:0]  n_active;
  logic [IDX_W-1:0]  last_idx;

  assign cfg_if.ready = 1'b1;
  assign cfg_acc      = cfg_if.valid & cfg_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= STEP_COUNT_RESET;
      for (int i = 0; i < NUM_STEPS; i++) begin
        steps_r[i] <= (i == 0) ? STEP0_RESET : ((i == 1) ? STEP1_RESET : '0);
      end
    end else if (cfg_acc) begin
      if (cfg_if.index == REG_STEP_COUNT) begin
        step_count_r <= cfg_if.data[IDX_W-1:0];
      end
      for (int i = 0; i < NUM_STEPS; i++) begin
        if (cfg_if.index == CFG_IDX_W'(REG_STEP_BASE + i)) begin
          steps_r[i] <= cfg_if.data;
        end
      end
    end
  end

  assign n_active = (step_count_r > IDX_W'(NUM_STEPS)) ? IDX_W'(NUM_STEPS) : step_count_r;
  assign last_idx = n_active - IDX_W'(1);

  // pipeline advance
  logic out_valid_r;
  logic en;

  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // stage 1: compare against every step position
  logic                    s1_valid_r;
  logic signed [POS_W-1:0] s1_pos_r;
  logic                    s1_nan_r;
  logic                    s1_alpha_r;
  logic [NUM_STEPS-1:0]    s1_gt_r;
  logic                    s1_lt0_r;
  logic [NUM_STEPS-1:0]    s1_gt_nxt;

  always_comb begin
    for (int i = 0; i < NUM_STEPS; i++) begin
      s1_gt_nxt[i] = $signed(steps_r[i][STEP_W-1 -: POS_W]) > in_if.position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos_r   <= in_if.position;
      s1_nan_r   <= in_if.position_is_nan;
      s1_alpha_r <= in_if.include_alpha;
      s1_gt_r    <= s1_gt_nxt;
      s1_lt0_r   <= $signed(steps_r[0][STEP_W-1 -: POS_W]) < in_if.position;
    end
  end

  // stage 2: clamp decision and bracketing steps
  logic                    s2_valid_r;
  logic signed [POS_W-1:0] s2_pos_r;
  logic                    s2_zero_r;
  logic                    s2_alpha_r;
  logic                    s2_interp_r;
  logic [IDX_W-1:0]        s2_lo_r;
  logic [IDX_W-1:0]        s2_hi_r;
  logic                    s2_zero_nxt;
  logic                    s2_interp_nxt;
  logic [IDX_W-1:0]        s2_lo_nxt;
  logic [IDX_W-1:0]        s2_hi_nxt;

  always_comb begin
    s2_zero_nxt   = s1_nan_r || (n_active == '0);
    s2_interp_nxt = 1'b0;
    s2_lo_nxt     = '0;
    s2_hi_nxt     = '0;
    if (s2_zero_nxt || !s1_lt0_r) begin
      s2_lo_nxt = '0;
      s2_hi_nxt = '0;
    end else if (!s1_gt_r[last_idx[SIDX_W-1:0]]) begin
      s2_lo_nxt = last_idx;
      s2_hi_nxt = last_idx;
    end else begin
      s2_interp_nxt = 1'b1;
      s2_hi_nxt     = last_idx;
      // first step above the position wins
      for (int i = NUM_STEPS - 2; i >= 1; i--) begin
        if ((IDX_W'(i) < last_idx) && s1_gt_r[i]) begin
          s2_hi_nxt = IDX_W'(i);
        end
      end
      s2_lo_nxt = s2_hi_nxt - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pos_r    <= s1_pos_r;
      s2_zero_r   <= s2_zero_nxt;
      s2_alpha_r  <= s1_alpha_r;
      s2_interp_r <= s2_interp_nxt;
      s2_lo_r     <= s2_lo_nxt;
      s2_hi_r     <= s2_hi_nxt;
    end
  end

  // stage 3: offset and span
  logic              s3_valid_r;
  div_t              s3_r;
  div_t              s3_nxt;
  logic [POS_W:0]    pos_lo_x;
  logic [POS_W:0]    pos_hi_x;
  logic [POS_W:0]    off_x;
  logic [POS_W:0]    span_x;

  always_comb begin
    pos_lo_x = {steps_r[s2_lo_r[SIDX_W-1:0]][STEP_W-1],
                steps_r[s2_lo_r[SIDX_W-1:0]][STEP_W-1 -: POS_W]};
    pos_hi_x = {steps_r[s2_hi_r[SIDX_W-1:0]][STEP_W-1],
                steps_r[s2_hi_r[SIDX_W-1:0]][STEP_W-1 -: POS_W]};
    off_x    = {s2_pos_r[POS_W-1], s2_pos_r} - pos_lo_x;
    span_x   = pos_hi_x - pos_lo_x;
    s3_nxt.quo    = '0;
    s3_nxt.lo_idx = s2_lo_r;
    s3_nxt.hi_idx = s2_hi_r;
    s3_nxt.zero   = s2_zero_r;
    s3_nxt.alpha  = s2_alpha_r;
    // clamped items run through with a zero fraction
    if (s2_interp_r) begin
      s3_nxt.rem  = off_x[POS_W-1:0];
      s3_nxt.span = span_x[POS_W-1:0];
    end else begin
      s3_nxt.rem  = '0;
      s3_nxt.span = POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

  // fraction divider, one quotient bit per stage
  logic div_valid [DIV_STAGES+1];
  div_t div_data  [DIV_STAGES+1];

  assign div_valid[0] = s3_valid_r;
  assign div_data[0]  = s3_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    gcm_div_stage #(
      .BIT (g)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (div_valid[g]),
      .in_data   (div_data[g]),
      .out_valid (div_valid[g+1]),
      .out_data  (div_data[g+1])
    );
  end

  // blend into the output register
  div_t              bl;
  logic [COLOR_W-1:0] col_lo;
  logic [COLOR_W-1:0] col_hi;
  logic [CHAN_W:0]   w_lo;
  logic [CHAN_W:0]   w_hi;
  logic [PROD_W-1:0] mix [4];
  logic [CHAN_W-1:0] chan_nxt [4];

  always_comb begin
    bl     = div_data[DIV_STAGES];
    col_lo = steps_r[bl.lo_idx[SIDX_W-1:0]][COLOR_W-1:0];
    col_hi = steps_r[bl.hi_idx[SIDX_W-1:0]][COLOR_W-1:0];
    w_hi   = {1'b0, bl.quo};
    w_lo   = (CHAN_W+1)'(1 << FRAC_W) - w_hi;
    for (int ch = 0; ch < 4; ch++) begin
      mix[ch] = PROD_W'(col_lo[COLOR_W-1-CHAN_W*ch -: CHAN_W]) * PROD_W'(w_lo)
              + PROD_W'(col_hi[COLOR_W-1-CHAN_W*ch -: CHAN_W]) * PROD_W'(w_hi);
      chan_nxt[ch] = bl.zero ? '0 : mix[ch][FRAC_W +: CHAN_W];
    end
  end

  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;
  logic [CHAN_W-1:0] alpha_r;
  logic              alpha_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r         <= chan_nxt[0];
      green_r       <= chan_nxt[1];
      blue_r        <= chan_nxt[2];
      alpha_r       <= bl.alpha ? chan_nxt[3] : '0;
      alpha_valid_r <= bl.alpha;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.red         = red_r;
  assign out_if.green       = green_r;
  assign out_if.blue        = blue_r;
  assign out_if.alpha       = alpha_r;
  assign out_if.alpha_valid = alpha_valid_r;

endmodule

>>> hdl/gcm_div_stage.sv
module gcm_div_stage
  import gcm_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  logic        valid_r;
  div_t        data_r;
  div_t        data_nxt;
  logic [POS_W:0] rem2;
  logic [POS_W:0] diff;

  // one restoring step: rem stays below span, so the doubled value fits one extra bit
  always_comb begin
    rem2     = {in_data.rem, 1'b0};
    diff     = rem2 - {1'b0, in_data.span};
    data_nxt = in_data;
    if (!diff[POS_W]) begin
      data_nxt.rem = diff[POS_W-1:0];
      data_nxt.quo[FRAC_W-1-BIT] = 1'b1;
    end else begin
      data_nxt.rem = rem2[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
